// ===== src/lpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Configuration register file
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SLOTS_CFG_W  = 4;
  localparam logic        REG_IDX_SLOTS = 1'b0;
  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET = 4'd8;

  // Running counters
  localparam int unsigned CNT_W = 32;

  // Per-item control broadcast to every cell
  typedef struct packed {
    logic en;      // item accepted this cycle
    logic hit;     // page found in the stack
    logic append;  // miss with a free slot
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/lru_page_replacement_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative LRU page tracker built as a row of shift-stack cells.
// ----------------------------------------------------------------------------
// Result: registered; it is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; all cells compare and
//   shift in parallel in the accept cycle; the result register frees when taken.
// Reset: stack empty (fill count zero), hit and miss counts zero, slot limit 8.
//   No clearing pass; the block takes items right after reset.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit
  import lpr_pkg::*;
#(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_W-1:0]      paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready,
  // reference items
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [PAGE_BITS-1:0]   page_i,
  // results
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        hit_o,
  output logic                        evicted_valid_o,
  output logic [PAGE_BITS-1:0]        evicted_page_o,
  output logic [CNT_W-1:0]            hit_total_o,
  output logic [CNT_W-1:0]            miss_total_o
);

  localparam int unsigned FW = $clog2(SLOTS + 1);

  logic [SLOTS_CFG_W-1:0] slots_cfg;
  logic [FW-1:0]          limit;

  logic [FW-1:0]          fill_q, fill_d;
  logic [CNT_W-1:0]       hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]       miss_cnt_q, miss_cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   hit_q, hit_d;
  logic                   ev_q, ev_d;
  logic [PAGE_BITS-1:0]   ev_page_q, ev_page_d;

  logic                   accept;
  logic                   found;
  logic                   append;
  cell_ctl_t              ctl;

  logic [PAGE_BITS-1:0]   pages [SLOTS];
  logic [PAGE_BITS-1:0]   uppers [SLOTS];
  logic [SLOTS:0]         seen;
  logic [SLOTS-1:0]       match;

  lpr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .slots_o (slots_cfg)
  );

  // zero acts as one, anything above the built depth as the depth
  always_comb begin
    if (slots_cfg == '0) begin
      limit = FW'(1);
    end else if (int'(slots_cfg) > int'(SLOTS)) begin
      limit = FW'(SLOTS);
    end else begin
      limit = FW'(slots_cfg);
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign seen[0] = 1'b0;
  assign found   = seen[SLOTS];
  assign append  = !found && (fill_q < limit);

  assign ctl.en     = accept;
  assign ctl.hit    = found;
  assign ctl.append = append;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == SLOTS - 1) begin : g_last
      assign uppers[k] = '0;
    end else begin : g_mid
      assign uppers[k] = pages[k+1];
    end

    lpr_cell #(
      .SLOTS     (SLOTS),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .fill_i     (fill_q),
      .ref_page_i (page_i),
      .upper_i    (uppers[k]),
      .seen_i     (seen[k]),
      .seen_o     (seen[k+1]),
      .match_o    (match[k]),
      .page_o     (pages[k])
    );
  end

  always_comb begin
    fill_d      = fill_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    ev_d        = ev_q;
    ev_page_d   = ev_page_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      hit_d       = found;
      ev_d        = !found && !append;
      ev_page_d   = (!found && !append) ? pages[0] : '0;
      if (found) begin
        if (hit_cnt_q != '1) begin
          hit_cnt_d = hit_cnt_q + CNT_W'(1);
        end
      end else begin
        if (miss_cnt_q != '1) begin
          miss_cnt_d = miss_cnt_q + CNT_W'(1);
        end
        if (append) begin
          fill_d = fill_q + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q     <= hit_d;
    ev_q      <= ev_d;
    ev_page_q <= ev_page_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_q;
  assign evicted_page_o  = ev_page_q;
  assign hit_total_o     = hit_cnt_q;
  assign miss_total_o    = miss_cnt_q;

  // a page is resident at most once
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one slot matches the reference");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= int'(SLOTS))
    else $error("fill count beyond built depth");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> fill_q >= $past(fill_q))
    else $error("fill count dropped");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && ev_q))
    else $error("hit reported together with an eviction");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !found && !append |-> fill_q != '0)
    else $error("eviction from an empty stack");

endmodule
`default_nettype wire

// ===== src/lpr_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_cell
// One slot of the LRU shift stack: holds a page, compares it against the
// reference and shifts down from its upper neighbor or loads the new page.
// ----------------------------------------------------------------------------
module lpr_cell
  import lpr_pkg::*;
#(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned IDX       = 0
) (
  input  wire logic                          clk_i,
  input  wire cell_ctl_t                     ctl_i,
  input  wire logic [$clog2(SLOTS+1)-1:0]    fill_i,
  input  wire logic [PAGE_BITS-1:0]          ref_page_i,
  input  wire logic [PAGE_BITS-1:0]          upper_i,
  input  wire logic                          seen_i,
  output logic                               seen_o,
  output logic                               match_o,
  output logic [PAGE_BITS-1:0]               page_o
);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid;
  logic                 is_top;
  logic                 is_free;
  logic                 shift_en;
  logic                 load_en;

  always_comb begin
    valid   = int'(fill_i) > int'(IDX);
    is_top  = int'(fill_i) == int'(IDX) + 1;
    is_free = int'(fill_i) == int'(IDX);
    match_o = valid && (page_q == ref_page_i);
    seen_o  = seen_i | match_o;
  end

  // On a hit only the cells at or above the matching one move down;
  // on an eviction every filled cell below the top moves down.
  always_comb begin
    shift_en = ctl_i.en && valid && !is_top &&
               (ctl_i.hit ? seen_o : !ctl_i.append);
    load_en  = ctl_i.en && (ctl_i.append ? is_free : is_top);
    page_d   = page_q;
    if (load_en) begin
      page_d = ref_page_i;
    end else if (shift_en) begin
      page_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign page_o = page_q;

endmodule
`default_nettype wire

// ===== src/lpr_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_cfg
// APB-style register file holding the slot limit.
// ----------------------------------------------------------------------------
module lpr_cfg
  import lpr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_W-1:0]      paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready,
  output logic [SLOTS_CFG_W-1:0]      slots_o
);

  logic [SLOTS_CFG_W-1:0] slots_q, slots_d;
  logic                   sel_slots;

  assign sel_slots = (paddr[2] == REG_IDX_SLOTS);
  assign pready    = 1'b1;

  always_comb begin
    slots_d = slots_q;
    if (psel && penable && pwrite && sel_slots) begin
      slots_d = pwdata[SLOTS_CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_slots) begin
      prdata = {{(DATA_W-SLOTS_CFG_W){1'b0}}, slots_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SLOTS_RESET;
    end else begin
      slots_q <= slots_d;
    end
  end

  assign slots_o = slots_q;

endmodule
`default_nettype wire

// ===== sim/lru_page_replacement_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_tb
// Self-checking bench for the LRU page replacement unit: a directed table of
// page references and slot-limit writes, then random reference streams.
// Results are checked against pinned rows or an in-bench LRU shift-stack predictor.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_tb;
  import lpr_pkg::*;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned PAGE_BITS = 16;
  localparam logic [ADDR_W-1:0] SLOTS_ADDR = ADDR_W'(REG_IDX_SLOTS) << 2;
  localparam int unsigned ROWS      = 24;
  localparam int unsigned SUB_ITEMS = 145;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    page_t            evicted_page;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } lru_result_t;

  typedef struct packed {
    logic        on;
    lru_result_t res;
  } pinned_t;

  typedef enum logic {ROW_PAGE, ROW_SLOTS} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    page_t       val;
    logic        pinned;
    lru_result_t res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  page_t                  page_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   hit_o;
  logic                   evicted_valid_o;
  page_t                  evicted_page_o;
  logic [CNT_W-1:0]       hit_total_o;
  logic [CNT_W-1:0]       miss_total_o;

  lru_page_replacement_unit #(
    .SLOTS     (SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_i          (page_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("lru_page_replacement_unit: mismatch");
    $finish;
  end

  // predictor state: slot 0 holds the least recently used page
  page_t                  lru_stack [SLOTS];
  int unsigned            lru_fill = 0;
  logic [SLOTS_CFG_W-1:0] slot_limit = SLOTS_RESET;
  logic [CNT_W-1:0]       hit_count = '0;
  logic [CNT_W-1:0]       miss_count = '0;

  lru_result_t lru_results_due [$];
  pinned_t     pinned_rows [$];
  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  page_t       page_pool [12];

  // pinned rows carry the result read straight off the LRU rules
  stim_row_t directed_rows [ROWS] = '{
    '{ROW_PAGE,  16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd0, 32'd1}},
    '{ROW_SLOTS, 16'd0,    1'b0, '0},  // zero limit acts as one slot
    '{ROW_PAGE,  16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1, 32'd1}},
    '{ROW_PAGE,  16'hFFFF, 1'b1, '{1'b0, 1'b1, 16'h0000, 32'd1, 32'd2}},
    '{ROW_PAGE,  16'h1234, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 32'd1, 32'd3}},
    '{ROW_SLOTS, 16'd15,   1'b0, '0},  // above depth acts as full depth
    '{ROW_PAGE,  16'h8000, 1'b0, '0},
    '{ROW_PAGE,  16'h0001, 1'b0, '0},
    '{ROW_PAGE,  16'h7FFF, 1'b0, '0},
    '{ROW_PAGE,  16'h00FF, 1'b0, '0},
    '{ROW_PAGE,  16'hFF00, 1'b0, '0},
    '{ROW_SLOTS, 16'd3,    1'b0, '0},  // limit now below fill
    '{ROW_PAGE,  16'h4321, 1'b1, '{1'b0, 1'b1, 16'h1234, 32'd1, 32'd9}},
    '{ROW_PAGE,  16'h8000, 1'b0, '0},
    '{ROW_PAGE,  16'h8000, 1'b0, '0},
    '{ROW_PAGE,  16'h7FFF, 1'b0, '0},
    '{ROW_SLOTS, 16'd8,    1'b0, '0},
    '{ROW_PAGE,  16'h0F0F, 1'b0, '0},
    '{ROW_PAGE,  16'hF0F0, 1'b0, '0},
    '{ROW_PAGE,  16'h3C3C, 1'b1, '{1'b0, 1'b1, 16'h0001, 32'd4, 32'd12}},
    '{ROW_SLOTS, 16'd1,    1'b0, '0},
    '{ROW_PAGE,  16'h5555, 1'b0, '0},
    '{ROW_PAGE,  16'hAAAA, 1'b0, '0},
    '{ROW_PAGE,  16'hAAAA, 1'b0, '0}
  };

  function automatic lru_result_t lru_reference(input page_t pg);
    lru_result_t r;
    int unsigned lim;
    int          pos;
    r   = '0;
    lim = (slot_limit == 0) ? 1 : ((slot_limit > SLOTS) ? SLOTS : int'(slot_limit));
    pos = -1;
    for (int i = 0; i < int'(lru_fill); i++) begin
      if (pos < 0 && lru_stack[i] == pg) pos = i;
    end
    if (pos >= 0) begin
      for (int k = pos; k + 1 < int'(lru_fill); k++) lru_stack[k] = lru_stack[k+1];
      lru_stack[lru_fill-1] = pg;
      r.hit = 1'b1;
      if (hit_count != '1) hit_count = hit_count + CNT_W'(1);
    end else begin
      if (miss_count != '1) miss_count = miss_count + CNT_W'(1);
      if (lru_fill < lim) begin
        lru_stack[lru_fill] = pg;
        lru_fill++;
      end else begin
        // fill never drops, so a lowered limit only swaps out the oldest page
        r.evicted      = 1'b1;
        r.evicted_page = lru_stack[0];
        for (int k = 0; k + 1 < int'(lru_fill); k++) lru_stack[k] = lru_stack[k+1];
        lru_stack[lru_fill-1] = pg;
      end
    end
    r.hit_total  = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    lru_result_t want;
    pinned_t     pin;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (lru_results_due.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = lru_results_due.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("evicted_valid", 32'(want.evicted), 32'(evicted_valid_o));
          check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page_o));
          check_field("hit_total", want.hit_total, hit_total_o);
          check_field("miss_total", want.miss_total, miss_total_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = lru_reference(page_i);
        pin  = pinned_rows.pop_front();
        lru_results_due.push_back(pin.on ? pin.res : want);
      end
    end
  end

  task automatic send_page(input page_t pg, input pinned_t pin);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    pinned_rows.push_back(pin);
    in_valid_i <= 1'b1;
    page_i     <= pg;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drains the pipe first; reads the value back afterwards
  task automatic write_slots(input logic [SLOTS_CFG_W-1:0] v);
    logic [DATA_W-1:0] wd;
    wd = DATA_W'($urandom());
    wd[SLOTS_CFG_W-1:0] = v;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lru_results_due.size() != 0);
    repeat (3) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOTS_ADDR;
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    slot_limit = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("slots_in_use", 32'(v), 32'(prdata[SLOTS_CFG_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned send_pct [3];
    int unsigned recv_pct [3];
    logic [SLOTS_CFG_W-1:0] limits [9];
    pinned_t no_pin;
    pinned_t pin;
    page_t   pg;
    send_pct = '{21, 69, 0};
    recv_pct = '{69, 21, 0};
    limits   = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd5, 4'd9, 4'd2, 4'd7, 4'd3};
    no_pin   = '0;
    send_idle = send_pct[0];
    recv_idle = recv_pct[0];

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SLOTS) begin
        write_slots(directed_rows[r].val[SLOTS_CFG_W-1:0]);
      end else begin
        pin.on  = directed_rows[r].pinned;
        pin.res = directed_rows[r].res;
        send_page(directed_rows[r].val, pin);
      end
    end

    for (int m = 0; m < 3; m++) begin
      for (int s = 0; s < 3; s++) begin
        write_slots((m == 2 && s == 2) ? SLOTS_CFG_W'($urandom_range(15)) : limits[m*3+s]);
        send_idle = send_pct[m];
        recv_idle = recv_pct[m];
        foreach (page_pool[i]) page_pool[i] = page_t'($urandom());
        // mostly a small working set so hits and evictions both show up
        for (int n = 0; n < SUB_ITEMS; n++) begin
          if ($urandom_range(99) < 75) pg = page_pool[$urandom_range(11)];
          else pg = page_t'($urandom());
          send_page(pg, no_pin);
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lru_results_due.size() != 0);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("lru_page_replacement_unit: match");
    end else begin
      $display("lru_page_replacement_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/lpr_pkg.sv
src/lpr_cell.sv
src/lpr_cfg.sv
src/lru_page_replacement_unit.sv
sim/lru_page_replacement_unit_tb.sv
